// ===== src/jrpc_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON-RPC extractor package
// Shared types and constants for the method and id extractor.
// ----------------------------------------------------------------------------
package jrpc_pkg;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_LEAD   = 3'd1,
    PH_SIGN   = 3'd2,
    PH_BODY   = 3'd3,
    PH_TAIL   = 3'd4,
    PH_OK     = 3'd5,
    PH_FAIL   = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    KM_IDLE   = 4'd0,
    KM_OPEN   = 4'd1,
    KM_M1     = 4'd2,
    KM_M2     = 4'd3,
    KM_M3     = 4'd4,
    KM_M4     = 4'd5,
    KM_M5     = 4'd6,
    KM_M6     = 4'd7,
    KM_M_WAIT = 4'd8,
    KM_I1     = 4'd9,
    KM_I2     = 4'd10,
    KM_I_WAIT = 4'd11
  } key_e;

  typedef enum logic [1:0] {
    DR_IDLE = 2'd0,
    DR_CHAR = 2'd1,
    DR_SUM  = 2'd2
  } drain_e;

  localparam int unsigned LenW = 5;
  localparam int unsigned IdW  = 31;

  // Summary of one finished message, handed from the scanner to the emitter.
  typedef struct packed {
    logic            method_found;
    logic [LenW-1:0] method_length;
    logic            id_found;
    logic [IdW-1:0]  id_value;
  } summary_t;

  function automatic logic ws4(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

  function automatic logic ws6(input logic [7:0] b);
    return ws4(b) || (b == 8'h0B) || (b == 8'h0C);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

// ===== src/jrpc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module jrpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/jrpc_scan.sv =====
// ----------------------------------------------------------------------------
// JSON-RPC scanner (front part)
// Follows nesting, strings and keys, stores the method bytes and parses id.
// ----------------------------------------------------------------------------
module jrpc_scan import jrpc_pkg::*; #(
  parameter int unsigned MethodMax = 32,
  parameter int unsigned DepthBits = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [7:0]                   byte_i,
  input  logic                         eom_i,
  input  logic [5:0]                   cap_i,
  output logic                         we_o,
  output logic [$clog2(MethodMax)-1:0] waddr_o,
  output logic [7:0]                   wdata_o,
  output logic                         done_o,
  output summary_t                     sum_o
);

  localparam int unsigned AW = $clog2(MethodMax);
  localparam int unsigned CapLim = (MethodMax < 32) ? MethodMax : 32;

  logic [DepthBits-1:0] depth_q, depth_d;
  logic                 instr_q, instr_d;
  logic                 esc_q, esc_d;
  key_e                 km_q, km_d;
  phase_e               mph_q, mph_d, iph_q, iph_d;
  logic [5:0]           slen_q, slen_d;
  logic [31:0]          acc_q, acc_d;
  logic                 neg_q, neg_d, ovf_q, ovf_d, stop_q, stop_d;
  logic [5:0]           cap;
  logic [35:0]          prod;
  logic [3:0]           dig;

  always_comb begin
    cap = (cap_i > 6'(CapLim)) ? 6'(CapLim) : cap_i;
  end

  assign dig  = byte_i[3:0];
  assign prod = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 36'(dig);

  always_comb begin
    depth_d = depth_q; instr_d = instr_q; esc_d = esc_q; km_d = km_q;
    mph_d = mph_q; iph_d = iph_q; slen_d = slen_q; acc_d = acc_q;
    neg_d = neg_q; ovf_d = ovf_q; stop_d = stop_q;
    we_o = 1'b0;
    waddr_o = slen_q[AW-1:0];
    wdata_o = byte_i;
    if (!stop_q && byte_i == 8'h00) begin
      stop_d = 1'b1;
    end else if (!stop_q) begin
      case (mph_q)
        PH_LEAD: begin
          if (!ws4(byte_i)) begin
            if (byte_i == 8'h22) begin
              mph_d = PH_BODY;
              slen_d = 6'd0;
            end else begin
              mph_d = PH_FAIL;
            end
          end
        end
        PH_BODY: begin
          if (byte_i == 8'h5C) begin
            mph_d = PH_FAIL;
          end else if (byte_i == 8'h22) begin
            mph_d = (slen_q >= cap) ? PH_FAIL : PH_OK;
          end else if (7'(slen_q) + 7'd1 >= 7'(cap)) begin
            mph_d = PH_FAIL;
          end else begin
            we_o = 1'b1;
            slen_d = slen_q + 6'd1;
          end
        end
        default: ;
      endcase
      case (iph_q)
        PH_LEAD: begin
          if (!ws6(byte_i)) begin
            if (byte_i == 8'h2B) begin
              iph_d = PH_SIGN;
            end else if (byte_i == 8'h2D) begin
              neg_d = 1'b1;
              iph_d = PH_SIGN;
            end else if (is_digit(byte_i)) begin
              acc_d = 32'(dig);
              iph_d = PH_BODY;
            end else begin
              iph_d = PH_FAIL;
            end
          end
        end
        PH_SIGN: begin
          if (is_digit(byte_i)) begin
            acc_d = 32'(dig);
            iph_d = PH_BODY;
          end else begin
            iph_d = PH_FAIL;
          end
        end
        PH_BODY: begin
          if (is_digit(byte_i)) begin
            if (!ovf_q) begin
              if (prod > 36'h7FFFFFFF) begin
                ovf_d = 1'b1;
                acc_d = 32'h80000000;
              end else begin
                acc_d = prod[31:0];
              end
            end
          end else if (ws4(byte_i)) begin
            iph_d = PH_TAIL;
          end else if (byte_i == 8'h2C || byte_i == 8'h7D) begin
            iph_d = PH_OK;
          end else begin
            iph_d = PH_FAIL;
          end
        end
        PH_TAIL: begin
          if (!ws4(byte_i)) begin
            iph_d = (byte_i == 8'h2C || byte_i == 8'h7D) ? PH_OK : PH_FAIL;
          end
        end
        default: ;
      endcase
      if (instr_q) begin
        case (km_q)
          KM_OPEN: km_d = (byte_i == 8'h6D) ? KM_M1 : (byte_i == 8'h69) ? KM_I1 : KM_IDLE;
          KM_M1:   km_d = (byte_i == 8'h65) ? KM_M2 : KM_IDLE;
          KM_M2:   km_d = (byte_i == 8'h74) ? KM_M3 : KM_IDLE;
          KM_M3:   km_d = (byte_i == 8'h68) ? KM_M4 : KM_IDLE;
          KM_M4:   km_d = (byte_i == 8'h6F) ? KM_M5 : KM_IDLE;
          KM_M5:   km_d = (byte_i == 8'h64) ? KM_M6 : KM_IDLE;
          KM_M6:   km_d = (byte_i == 8'h22) ? KM_M_WAIT : KM_IDLE;
          KM_I1:   km_d = (byte_i == 8'h64) ? KM_I2 : KM_IDLE;
          KM_I2:   km_d = (byte_i == 8'h22) ? KM_I_WAIT : KM_IDLE;
          default: km_d = KM_IDLE;
        endcase
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (byte_i == 8'h5C) begin
          esc_d = 1'b1;
        end else if (byte_i == 8'h22) begin
          instr_d = 1'b0;
        end
      end else if ((km_q == KM_M_WAIT || km_q == KM_I_WAIT) && ws4(byte_i)) begin
        km_d = km_q;
      end else if ((km_q == KM_M_WAIT || km_q == KM_I_WAIT) && byte_i == 8'h3A) begin
        if (km_q == KM_M_WAIT) begin
          if (mph_q == PH_SEARCH) mph_d = PH_LEAD;
        end else if (iph_q == PH_SEARCH) begin
          iph_d = PH_LEAD;
        end
        km_d = KM_IDLE;
      end else begin
        km_d = KM_IDLE;
        if (byte_i == 8'h22) begin
          instr_d = 1'b1;
          if (depth_q == DepthBits'(1)) km_d = KM_OPEN;
        end else if (byte_i == 8'h7B || byte_i == 8'h5B) begin
          depth_d = depth_q + DepthBits'(1);
        end else if (byte_i == 8'h7D || byte_i == 8'h5D) begin
          depth_d = depth_q - DepthBits'(1);
        end
      end
    end
  end

  logic mf, idf;
  always_comb begin
    mf  = (mph_d == PH_OK);
    idf = (iph_d == PH_OK) && !ovf_d && !(neg_d && acc_d != 32'd0);
    sum_o.method_found  = mf;
    sum_o.method_length = mf ? ((slen_d > 6'd31) ? 5'd31 : slen_d[4:0]) : 5'd0;
    sum_o.id_found      = idf;
    sum_o.id_value      = idf ? acc_d[30:0] : 31'd0;
  end

  assign done_o = step_i && eom_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0; instr_q <= 1'b0; esc_q <= 1'b0; km_q <= KM_IDLE;
      mph_q <= PH_SEARCH; iph_q <= PH_SEARCH; slen_q <= 6'd0; acc_q <= 32'd0;
      neg_q <= 1'b0; ovf_q <= 1'b0; stop_q <= 1'b0;
    end else if (step_i && eom_i) begin
      depth_q <= '0; instr_q <= 1'b0; esc_q <= 1'b0; km_q <= KM_IDLE;
      mph_q <= PH_SEARCH; iph_q <= PH_SEARCH; slen_q <= 6'd0; acc_q <= 32'd0;
      neg_q <= 1'b0; ovf_q <= 1'b0; stop_q <= 1'b0;
    end else if (step_i) begin
      depth_q <= depth_d; instr_q <= instr_d; esc_q <= esc_d; km_q <= km_d;
      mph_q <= mph_d; iph_q <= iph_d; slen_q <= slen_d; acc_q <= acc_d;
      neg_q <= neg_d; ovf_q <= ovf_d; stop_q <= stop_d;
    end
  end

endmodule

// ===== src/jrpc_emit.sv =====
// ----------------------------------------------------------------------------
// JSON-RPC emitter (back part)
// Reads stored method bytes from RAM and sends them, then the summary.
// ----------------------------------------------------------------------------
module jrpc_emit import jrpc_pkg::*; #(
  parameter int unsigned MethodMax = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  summary_t                     job_i,
  output logic                         job_ready_o,
  output logic [$clog2(MethodMax)-1:0] raddr_o,
  input  logic [7:0]                   rdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         item_kind_o,
  output logic [7:0]                   method_char_o,
  output logic                         method_found_o,
  output logic [4:0]                   method_length_o,
  output logic                         id_found_o,
  output logic [30:0]                  id_value_o,
  output logic                         final_item_o
);

  localparam int unsigned AW = $clog2(MethodMax);

  drain_e          st_q, st_d;
  summary_t        job_q;
  logic [LenW-1:0] idx_q, idx_d;
  logic            rd_ok_q, rd_ok_d;
  logic            take, adv;

  assign adv = out_ready_i || !out_valid_o;
  assign take = job_valid_i && job_ready_o;

  always_comb begin
    st_d = st_q;
    idx_d = idx_q;
    case (st_q)
      DR_IDLE: begin
        if (job_valid_i) begin
          idx_d = '0;
          st_d = (job_i.method_length != '0) ? DR_CHAR : DR_SUM;
        end
      end
      DR_CHAR: begin
        if (rd_ok_q && adv) begin
          idx_d = idx_q + 5'd1;
          if (idx_q + 5'd1 == job_q.method_length) st_d = DR_SUM;
        end
      end
      DR_SUM: begin
        if (adv) st_d = DR_IDLE;
      end
      default: st_d = DR_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (st_q == DR_IDLE);
    rd_ok_d = (st_q == DR_CHAR) && !(rd_ok_q && adv);
    raddr_o = AW'(idx_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DR_IDLE; idx_q <= '0; rd_ok_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d;
      rd_ok_q <= (st_d == DR_CHAR) && (st_q != DR_CHAR || rd_ok_d || (rd_ok_q && adv));
      if (adv) out_valid_o <= ((st_q == DR_CHAR) && rd_ok_q) || (st_q == DR_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_i;
    if (adv) begin
      item_kind_o     <= (st_q == DR_SUM);
      method_char_o   <= (st_q == DR_SUM) ? 8'd0 : rdata_i;
      method_found_o  <= (st_q == DR_SUM) && job_q.method_found;
      method_length_o <= (st_q == DR_SUM) ? job_q.method_length : 5'd0;
      id_found_o      <= (st_q == DR_SUM) && job_q.id_found;
      id_value_o      <= (st_q == DR_SUM) ? job_q.id_value : 31'd0;
      final_item_o    <= (st_q == DR_SUM);
    end
  end

endmodule

// ===== src/json_rpc_method_id_extractor_top.sv =====
// ----------------------------------------------------------------------------
// JSON-RPC method and id extractor
// Scans a JSON message a byte at a time and reports method and id.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | text_byte_i, end_of_message_i
// out     | output    | out_valid_o/out_ready_i | item_kind_o .. final_item_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i
//
// One byte is taken every cycle while no message is being emitted.
// The final byte of a message hands it to the emitter, which sends one
// method byte per cycle from the RAM read port while the output is not
// stalled, then the summary. The next message is held until the emitter
// has loaded the summary of the previous one into its output register.
// Reset clears all control state; capacity returns to 32.
module json_rpc_method_id_extractor_top import jrpc_pkg::*; #(
  parameter int unsigned MethodMax = 32,
  parameter int unsigned DepthBits = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        item_kind_o,
  output logic [7:0]  method_char_o,
  output logic        method_found_o,
  output logic [4:0]  method_length_o,
  output logic        id_found_o,
  output logic [30:0] id_value_o,
  output logic        final_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(MethodMax);

  logic [5:0]    cap_q;
  logic          busy_q;
  logic          step, we, done, job_ready;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  summary_t      sum;
  summary_t      job_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = !busy_q && job_ready;
  assign step = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 6'd32;
      busy_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (done) busy_q <= 1'b1;
      else if (busy_q && job_ready) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) job_q <= sum;
  end

  jrpc_scan #(.MethodMax(MethodMax), .DepthBits(DepthBits)) u_scan (
    .clk_i, .rst_ni, .step_i(step), .byte_i(text_byte_i), .eom_i(end_of_message_i),
    .cap_i(cap_q), .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .done_o(done),
    .sum_o(sum)
  );

  jrpc_ram #(.Width(8), .Depth(MethodMax)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata)
  );

  jrpc_emit #(.MethodMax(MethodMax)) u_emit (
    .clk_i, .rst_ni, .job_valid_i(busy_q), .job_i(job_q), .job_ready_o(job_ready),
    .raddr_o(raddr), .rdata_i(rdata), .out_valid_o, .out_ready_i, .item_kind_o,
    .method_char_o, .method_found_o, .method_length_o, .id_found_o, .id_value_o,
    .final_item_o
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Method and id extractor testbench
// Streams JSON messages into the extractor with random idle cycles on both
// channels, predicts every method byte and summary item, and compares each
// output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import jrpc_pkg::*;

  typedef enum logic [1:0] {
    JOB_BYTE  = 2'd0,
    JOB_CFG   = 2'd1,
    JOB_DRAIN = 2'd2
  } job_e;

  typedef struct {
    job_e       op;
    logic [7:0] b;
    logic       e;
    logic [5:0] c;
  } job_t;

  typedef struct {
    logic        kind;
    logic [7:0]  ch;
    logic        mf;
    logic [4:0]  ml;
    logic        idf;
    logic [30:0] idv;
    logic        fin;
  } emit_t;

  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned Settle     = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = '0;
  logic        eom = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        item_kind;
  logic [7:0]  method_char;
  logic        method_found;
  logic [4:0]  method_length;
  logic        id_found;
  logic [30:0] id_value;
  logic        final_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  job_t  jobs[$];
  emit_t expected_items[$];
  int    errors = 0;
  int    bytes_taken = 0;
  int    settle_cnt = 0;
  int    idle_cycles = 0;
  bit    quiet;

  // Predictor state.
  logic [5:0]  cap_reg = 6'd32;
  logic [7:0]  p_depth;
  logic        p_in_str, p_esc, p_stopped, p_neg, p_ovf;
  key_e        p_key;
  phase_e      p_mph, p_iph;
  logic [7:0]  p_store[32];
  int unsigned p_len;
  logic [31:0] p_acc;

  json_rpc_method_id_extractor_top dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .text_byte_i(text_byte), .end_of_message_i(eom),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .item_kind_o(item_kind), .method_char_o(method_char),
    .method_found_o(method_found), .method_length_o(method_length),
    .id_found_o(id_found), .id_value_o(id_value), .final_item_o(final_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  assign quiet = (bytes_taken >= 200) && (bytes_taken < 320);

  function automatic bit blank4(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic bit blank6(logic [7:0] b);
    return blank4(b) || b == 8'h0B || b == 8'h0C;
  endfunction

  function automatic bit digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic clear_scan();
    p_depth = '0; p_in_str = 0; p_esc = 0; p_key = KM_IDLE;
    p_mph = PH_SEARCH; p_iph = PH_SEARCH; p_len = 0; p_acc = '0;
    p_neg = 0; p_ovf = 0; p_stopped = 0;
  endtask

  task automatic method_step(logic [7:0] b);
    int unsigned cap;
    cap = (cap_reg > 32) ? 32 : cap_reg;
    if (p_mph == PH_LEAD) begin
      if (blank4(b)) return;
      if (b == "\"") begin
        p_mph = PH_BODY; p_len = 0;
      end else p_mph = PH_FAIL;
    end else if (p_mph == PH_BODY) begin
      if (b == "\\") p_mph = PH_FAIL;
      else if (b == "\"") p_mph = (p_len >= cap) ? PH_FAIL : PH_OK;
      else if (p_len + 1 >= cap) p_mph = PH_FAIL;
      else begin
        p_store[p_len % 32] = b;
        p_len++;
      end
    end
  endtask

  task automatic id_step(logic [7:0] b);
    logic [63:0] v;
    case (p_iph)
      PH_LEAD: begin
        if (blank6(b)) return;
        if (b == "+") p_iph = PH_SIGN;
        else if (b == "-") begin
          p_neg = 1; p_iph = PH_SIGN;
        end else if (digit(b)) begin
          p_acc = b - "0"; p_iph = PH_BODY;
        end else p_iph = PH_FAIL;
      end
      PH_SIGN: begin
        if (digit(b)) begin
          p_acc = b - "0"; p_iph = PH_BODY;
        end else p_iph = PH_FAIL;
      end
      PH_BODY: begin
        if (digit(b)) begin
          if (!p_ovf) begin
            v = 64'(p_acc) * 10 + (b - "0");
            if (v > 64'h7FFF_FFFF) begin
              p_ovf = 1; v = 64'h8000_0000;
            end
            p_acc = v[31:0];
          end
        end else if (blank4(b)) p_iph = PH_TAIL;
        else if (b == "," || b == "}") p_iph = PH_OK;
        else p_iph = PH_FAIL;
      end
      PH_TAIL: begin
        if (blank4(b)) return;
        p_iph = (b == "," || b == "}") ? PH_OK : PH_FAIL;
      end
      default: ;
    endcase
  endtask

  task automatic key_step(logic [7:0] b);
    case (p_key)
      KM_OPEN: p_key = (b == "m") ? KM_M1 : (b == "i") ? KM_I1 : KM_IDLE;
      KM_M1:   p_key = (b == "e") ? KM_M2 : KM_IDLE;
      KM_M2:   p_key = (b == "t") ? KM_M3 : KM_IDLE;
      KM_M3:   p_key = (b == "h") ? KM_M4 : KM_IDLE;
      KM_M4:   p_key = (b == "o") ? KM_M5 : KM_IDLE;
      KM_M5:   p_key = (b == "d") ? KM_M6 : KM_IDLE;
      KM_M6:   p_key = (b == "\"") ? KM_M_WAIT : KM_IDLE;
      KM_I1:   p_key = (b == "d") ? KM_I2 : KM_IDLE;
      KM_I2:   p_key = (b == "\"") ? KM_I_WAIT : KM_IDLE;
      default: p_key = KM_IDLE;
    endcase
  endtask

  task automatic scan_step(logic [7:0] b);
    if (p_mph == PH_LEAD || p_mph == PH_BODY) method_step(b);
    if (p_iph inside {PH_LEAD, PH_SIGN, PH_BODY, PH_TAIL}) id_step(b);
    if (p_in_str) begin
      key_step(b);
      if (p_esc) p_esc = 0;
      else if (b == "\\") p_esc = 1;
      else if (b == "\"") p_in_str = 0;
      return;
    end
    if (p_key == KM_M_WAIT || p_key == KM_I_WAIT) begin
      if (blank4(b)) return;
      if (b == ":") begin
        if (p_key == KM_M_WAIT) begin
          if (p_mph == PH_SEARCH) p_mph = PH_LEAD;
        end else if (p_iph == PH_SEARCH) p_iph = PH_LEAD;
        p_key = KM_IDLE;
        return;
      end
    end
    p_key = KM_IDLE;
    if (b == "\"") begin
      p_in_str = 1;
      if (p_depth == 8'd1) p_key = KM_OPEN;
    end else if (b == "{" || b == "[") p_depth = p_depth + 8'd1;
    else if (b == "}" || b == "]") p_depth = p_depth - 8'd1;
  endtask

  task automatic predict_byte(logic [7:0] b, logic e);
    emit_t r;
    bit mf, idf;
    int unsigned ml;
    if (!p_stopped) begin
      if (b == 8'h00) p_stopped = 1;
      else scan_step(b);
    end
    if (!e) return;
    mf = (p_mph == PH_OK);
    ml = mf ? p_len : 0;
    if (ml > 31) ml = 31;
    idf = (p_iph == PH_OK) && !p_ovf && !(p_neg && p_acc != 0);
    for (int k = 0; k < ml; k++) begin
      r = '{1'b0, p_store[k % 32], 1'b0, 5'd0, 1'b0, 31'd0, 1'b0};
      expected_items.push_back(r);
    end
    r = '{1'b1, 8'd0, mf, ml[4:0], idf, idf ? p_acc[30:0] : 31'd0, 1'b1};
    expected_items.push_back(r);
    clear_scan();
  endtask

  // Driver: bytes, register writes and drain pauses in queue order.
  always @(posedge clk_i or negedge rst_ni) begin
    bit nv, nc;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nv = in_valid;
      nc = cfg_valid;
      if (in_valid && in_ready) begin
        predict_byte(text_byte, eom);
        void'(jobs.pop_front());
        bytes_taken++;
        nv = 0;
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        void'(jobs.pop_front());
        nc = 0;
      end
      if (!nv && !nc && jobs.size() > 0) begin
        case (jobs[0].op)
          JOB_BYTE: if (quiet || $urandom_range(0, 99) >= 6) begin
            text_byte <= jobs[0].b;
            eom <= jobs[0].e;
            nv = 1;
          end
          JOB_CFG: begin
            cfg_data <= jobs[0].c;
            nc = 1;
          end
          default: begin
            if (expected_items.size() == 0) settle_cnt++;
            if (settle_cnt >= Settle) begin
              settle_cnt = 0;
              void'(jobs.pop_front());
            end
          end
        endcase
      end
      in_valid <= nv;
      cfg_valid <= nc;
    end
  end

  // Monitor: checks every output transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    emit_t x;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_items.size() == 0) begin
          $error("output transaction with nothing predicted");
          errors++;
        end else begin
          x = expected_items.pop_front();
          if (item_kind !== x.kind) begin
            $error("item_kind exp %0d got %0d", x.kind, item_kind); errors++;
          end
          if (method_char !== x.ch) begin
            $error("method_char exp %0h got %0h", x.ch, method_char); errors++;
          end
          if (method_found !== x.mf) begin
            $error("method_found exp %0d got %0d", x.mf, method_found); errors++;
          end
          if (method_length !== x.ml) begin
            $error("method_length exp %0d got %0d", x.ml, method_length); errors++;
          end
          if (id_found !== x.idf) begin
            $error("id_found exp %0d got %0d", x.idf, id_found); errors++;
          end
          if (id_value !== x.idv) begin
            $error("id_value exp %0d got %0d", x.idv, id_value); errors++;
          end
          if (final_item !== x.fin) begin
            $error("final_item exp %0d got %0d", x.fin, final_item); errors++;
          end
        end
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b, logic e);
    jobs.push_back('{JOB_BYTE, b, e, 6'd0});
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  task automatic set_capacity(logic [5:0] c);
    jobs.push_back('{JOB_DRAIN, 8'd0, 1'b0, 6'd0});
    jobs.push_back('{JOB_CFG, 8'd0, 1'b0, c});
  endtask

  function automatic string pick_ws();
    case ($urandom_range(0, 5))
      0: return " ";
      1: return "\t";
      2: return "\r\n";
      default: return "";
    endcase
  endfunction

  function automatic string pick_name(int unsigned n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%c", $urandom_range(8'h21, 8'h7E))};
    for (int i = 0; i < s.len(); i++) if (s[i] == "\"" || s[i] == "\\") s[i] = "_";
    return s;
  endfunction

  function automatic string pick_id();
    case ($urandom_range(0, 11))
      0: return "-0";
      1: return $sformatf("-%0d", $urandom_range(1, 999));
      2: return "2147483647";
      3: return "2147483648";
      4: return "99999999999";
      5: return $sformatf("+%0d", $urandom_range(0, 9999));
      6: return "x";
      7: return $sformatf("%c%0d", 8'h0B, $urandom_range(0, 99));
      8: return "\"7\"";
      default: return $sformatf("%0d", $urandom);
    endcase
  endfunction

  task automatic random_message();
    string m, d, s;
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) push_byte($urandom_range(0, 255), i == n - 1);
      return;
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    m = {"\"method\"", pick_ws(), ":", pick_ws()};
    case ($urandom_range(0, 9))
      0: m = {m, "\"a\\nb\""};
      1: m = {m, "42"};
      default: m = {m, "\"", pick_name(n), "\""};
    endcase
    d = {"\"id\"", pick_ws(), ":", pick_ws(), pick_id(), pick_ws()};
    s = $urandom_range(0, 1) ? {m, ",", d} : {d, ",", m};
    if ($urandom_range(0, 4) == 0) s = {"\"x\":{\"id\":5},", s};
    if ($urandom_range(0, 6) == 0) s = {"\"k\":\"q\\\"id\\\"\",", s};
    s = {"{", pick_ws(), s, "}"};
    if ($urandom_range(0, 9) == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
    if ($urandom_range(0, 14) == 0) begin
      n = $urandom_range(0, s.len() - 1);
      for (int i = 0; i < n; i++) push_byte(s[i], 1'b0);
      push_byte(8'h00, 1'b0);
      push_text("{\"id\":1}");
    end else push_text(s);
  endtask

  initial begin
    logic [5:0] caps[6];
    clear_scan();
    caps = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd5, 6'd3};
    push_text("{\"method\":\"ping\",\"id\":7}");
    push_text("{\"id\":-0}");
    push_text("}}{\"id\":1}");
    push_byte(8'hFF, 1'b1);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 6) set_capacity(caps[ph]);
      else set_capacity($urandom_range(0, 63));
      for (int i = 0; i < 2; i++) random_message();
      if (ph == 2) begin
        push_text("{\"method\":\"\",\"id\":3 }");
        push_text("{\"method\":\"z\",\"id\":4}");
      end
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (jobs.size() > 0 || expected_items.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
